// ===== hdl/p2ht_pkg.sv =====
package p2ht_pkg;

  localparam int COORD_BITS = 24;
  localparam int ROW_BITS   = COORD_BITS + 1;
  localparam int REG_BITS   = 16;
  localparam int DEN_BITS   = REG_BITS + 1;
  localparam int MUL_BITS   = 2 * REG_BITS;
  localparam int PROD_BITS  = DEN_BITS + REG_BITS;
  localparam int SUM_BITS   = PROD_BITS + 1;
  localparam int IN_W       = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_W      = ((COORD_BITS + ROW_BITS + 7) / 8) * 8;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;

  localparam logic [REG_BITS-1:0] HALF_WIDTH_RST = 16'd443;
  localparam logic [REG_BITS-1:0] ROW_HEIGHT_RST = 16'd384;
  localparam logic [REG_BITS-1:0] TILE_RISE_RST  = 16'd128;

  typedef enum logic [1:0] {
    REG_HALF_WIDTH = 2'd0,
    REG_ROW_HEIGHT = 2'd1,
    REG_TILE_RISE  = 2'd2
  } reg_idx_t;

  // effective geometry, zero divisors already forced to one
  typedef struct packed {
    logic [REG_BITS-1:0] half_width;
    logic [REG_BITS-1:0] row_height;
    logic [REG_BITS-1:0] tile_rise;
  } cfg_t;

  typedef struct packed {
    logic [ROW_BITS-1:0]   row;
    logic [COORD_BITS-1:0] col;
  } tile_t;

endpackage

// ===== hdl/p2ht_cfg.sv =====
module p2ht_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [p2ht_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [p2ht_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [p2ht_pkg::DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready,
  output p2ht_pkg::cfg_t             cfg
);
  import p2ht_pkg::*;

  logic [REG_BITS-1:0] half_width_r;
  logic [REG_BITS-1:0] row_height_r;
  logic [REG_BITS-1:0] tile_rise_r;
  reg_idx_t            idx;
  logic                wr;

  assign idx        = reg_idx_t'(cfg_paddr[3:2]);
  assign wr         = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_width_r <= HALF_WIDTH_RST;
      row_height_r <= ROW_HEIGHT_RST;
      tile_rise_r  <= TILE_RISE_RST;
    end else if (wr) begin
      case (idx)
        REG_HALF_WIDTH: half_width_r <= cfg_pwdata[REG_BITS-1:0];
        REG_ROW_HEIGHT: row_height_r <= cfg_pwdata[REG_BITS-1:0];
        REG_TILE_RISE:  tile_rise_r  <= cfg_pwdata[REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_HALF_WIDTH: cfg_prdata = DATA_W'(half_width_r);
      REG_ROW_HEIGHT: cfg_prdata = DATA_W'(row_height_r);
      REG_TILE_RISE:  cfg_prdata = DATA_W'(tile_rise_r);
      default:        cfg_prdata = '0;
    endcase
  end

  assign cfg.half_width = (half_width_r == '0) ? REG_BITS'(1) : half_width_r;
  assign cfg.row_height = (row_height_r == '0) ? REG_BITS'(1) : row_height_r;
  assign cfg.tile_rise  = tile_rise_r;

endmodule

// ===== hdl/p2ht_div.sv =====
module p2ht_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic [p2ht_pkg::COORD_BITS-1:0] num_x,
  input  logic [p2ht_pkg::COORD_BITS-1:0] num_y,
  input  logic [p2ht_pkg::DEN_BITS-1:0]   den_x,
  input  logic [p2ht_pkg::DEN_BITS-1:0]   den_y,
  output logic                          out_vld,
  output logic [p2ht_pkg::COORD_BITS-1:0] quo_x,
  output logic [p2ht_pkg::COORD_BITS-1:0] quo_y,
  output logic [p2ht_pkg::DEN_BITS-1:0]   rem_x,
  output logic [p2ht_pkg::DEN_BITS-1:0]   rem_y
);
  import p2ht_pkg::*;

  // restoring division, one quotient bit per stage, both lanes in step
  logic                  vld_r [COORD_BITS];
  logic [COORD_BITS-1:0] nx_r  [COORD_BITS];
  logic [COORD_BITS-1:0] ny_r  [COORD_BITS];
  logic [COORD_BITS-1:0] qx_r  [COORD_BITS];
  logic [COORD_BITS-1:0] qy_r  [COORD_BITS];
  logic [DEN_BITS-1:0]   rx_r  [COORD_BITS];
  logic [DEN_BITS-1:0]   ry_r  [COORD_BITS];

  for (genvar s = 0; s < COORD_BITS; s++) begin : g_stage
    logic                  pv;
    logic [COORD_BITS-1:0] pnx, pny, pqx, pqy;
    logic [DEN_BITS-1:0]   prx, pry;
    logic [DEN_BITS:0]     tx, ty;
    logic                  gx, gy;

    if (s == 0) begin : g_first
      assign pv  = in_vld;
      assign pnx = num_x;
      assign pny = num_y;
      assign pqx = '0;
      assign pqy = '0;
      assign prx = '0;
      assign pry = '0;
    end else begin : g_next
      assign pv  = vld_r[s-1];
      assign pnx = nx_r[s-1];
      assign pny = ny_r[s-1];
      assign pqx = qx_r[s-1];
      assign pqy = qy_r[s-1];
      assign prx = rx_r[s-1];
      assign pry = ry_r[s-1];
    end

    assign tx = {prx, pnx[COORD_BITS-1]};
    assign ty = {pry, pny[COORD_BITS-1]};
    assign gx = (tx >= {1'b0, den_x});
    assign gy = (ty >= {1'b0, den_y});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nx_r[s] <= {pnx[COORD_BITS-2:0], 1'b0};
        ny_r[s] <= {pny[COORD_BITS-2:0], 1'b0};
        qx_r[s] <= {pqx[COORD_BITS-2:0], gx};
        qy_r[s] <= {pqy[COORD_BITS-2:0], gy};
        rx_r[s] <= gx ? DEN_BITS'(tx - {1'b0, den_x}) : tx[DEN_BITS-1:0];
        ry_r[s] <= gy ? DEN_BITS'(ty - {1'b0, den_y}) : ty[DEN_BITS-1:0];
      end
    end
  end

  assign out_vld = vld_r[COORD_BITS-1];
  assign quo_x   = qx_r[COORD_BITS-1];
  assign quo_y   = qy_r[COORD_BITS-1];
  assign rem_x   = rx_r[COORD_BITS-1];
  assign rem_y   = ry_r[COORD_BITS-1];

endmodule

// ===== hdl/p2ht_slope.sv =====
module p2ht_slope (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  p2ht_pkg::cfg_t                cfg,
  input  logic                          in_vld,
  input  logic [p2ht_pkg::COORD_BITS-1:0] quo_x,
  input  logic [p2ht_pkg::COORD_BITS-1:0] quo_y,
  input  logic [p2ht_pkg::DEN_BITS-1:0]   rem_x,
  input  logic [p2ht_pkg::DEN_BITS-1:0]   rem_y,
  output logic                          out_vld,
  output p2ht_pkg::tile_t               tile
);
  import p2ht_pkg::*;

  // stage a: products
  logic                  a_vld_r;
  logic [COORD_BITS-1:0] a_x_r, a_y_r;
  logic [MUL_BITS-1:0]   a_lhs_r, a_rh_r;
  logic [PROD_BITS-1:0]  a_rox_r;
  logic                  a_ge_r;
  logic [MUL_BITS-1:0]   a_lhs_nxt, a_rh_nxt;
  logic [PROD_BITS-1:0]  a_rox_nxt;

  // stage b: edge decisions
  logic                  b_vld_r;
  logic [COORD_BITS-1:0] b_x_r, b_y_r;
  logic                  b_dx_r, b_dy_r;
  logic                  b_dx_nxt, b_dy_nxt;
  logic [SUM_BITS-1:0]   lhs_w, rh_w, rox_w, s_lr, s_lh;
  logic                  c_above_l, c_above_r, c_odd_r, c_odd_l;

  // stage c: adjusted tile
  logic                  c_vld_r;
  tile_t                 c_tile_r;

  assign a_lhs_nxt = rem_y[REG_BITS-1:0] * cfg.half_width;
  assign a_rh_nxt  = cfg.tile_rise * cfg.half_width;
  assign a_rox_nxt = rem_x * cfg.tile_rise;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_vld;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_x_r   <= quo_x;
      a_y_r   <= quo_y;
      a_lhs_r <= a_lhs_nxt;
      a_rh_r  <= a_rh_nxt;
      a_rox_r <= a_rox_nxt;
      a_ge_r  <= (rem_x >= {1'b0, cfg.half_width});
    end
  end

  assign lhs_w = SUM_BITS'(a_lhs_r);
  assign rh_w  = SUM_BITS'(a_rh_r);
  assign rox_w = SUM_BITS'(a_rox_r);
  assign s_lr  = lhs_w + rox_w;
  assign s_lh  = lhs_w + rh_w;

  assign c_above_l = (s_lr < rh_w);
  assign c_above_r = (s_lh < rox_w);
  assign c_odd_r   = (s_lr < {rh_w[SUM_BITS-2:0], 1'b0});
  assign c_odd_l   = (lhs_w < rox_w);

  always_comb begin
    b_dx_nxt = 1'b0;
    b_dy_nxt = 1'b0;
    if (!a_y_r[0]) begin
      if (c_above_l) begin
        b_dx_nxt = 1'b1;
        b_dy_nxt = 1'b1;
      end else if (c_above_r) begin
        b_dy_nxt = 1'b1;
      end
    end else if (a_ge_r) begin
      b_dy_nxt = c_odd_r;
    end else if (c_odd_l) begin
      b_dy_nxt = 1'b1;
    end else begin
      b_dx_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_x_r  <= a_x_r;
      b_y_r  <= a_y_r;
      b_dx_r <= b_dx_nxt;
      b_dy_r <= b_dy_nxt;
      c_tile_r.col <= b_x_r - COORD_BITS'(b_dx_r);
      c_tile_r.row <= {1'b0, b_y_r} - ROW_BITS'(b_dy_r);
    end
  end

  assign out_vld = c_vld_r;
  assign tile    = c_tile_r;

endmodule

// ===== hdl/p2ht_skid.sv =====
module p2ht_skid (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_vld,
  input  p2ht_pkg::tile_t in_tile,
  output logic            en,
  output logic            out_tvalid,
  input  logic            out_tready,
  output p2ht_pkg::tile_t out_tile
);
  import p2ht_pkg::*;

  logic  out_vld_r;
  logic  skid_vld_r;
  tile_t out_tile_r;
  tile_t skid_tile_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_tready) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end
    end else if (in_vld) begin
      if (!out_vld_r || out_tready) begin
        out_vld_r <= 1'b1;
      end else begin
        skid_vld_r <= 1'b1;
      end
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_tready) begin
        out_tile_r <= skid_tile_r;
      end
    end else if (in_vld) begin
      if (!out_vld_r || out_tready) begin
        out_tile_r <= in_tile;
      end else begin
        skid_tile_r <= in_tile;
      end
    end
  end

  assign en         = !skid_vld_r;
  assign out_tvalid = out_vld_r;
  assign out_tile   = out_tile_r;

endmodule

// ===== hdl/point_to_hex_tile_core.sv =====
// Pipeline: an accepted item passes through 24 divider stages, 3 slope/adjust
// stages and 1 output register before its result appears on out_tvalid.
// Throughput: one item per cycle while in_tready is high; a full skid register at
// the output stalls the 24-stage restoring divider, one quotient bit per stage.
// Reset: synchronous, active low; clears all valid bits and loads the
// register defaults (half_width 443, row_height 384, tile_rise 128).
module point_to_hex_tile_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [p2ht_pkg::IN_W-1:0]   in_tdata,   // point_x, point_y
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [p2ht_pkg::OUT_W-1:0]  out_tdata,  // tile_col, tile_row, zero pad
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [p2ht_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [p2ht_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [p2ht_pkg::DATA_W-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import p2ht_pkg::*;

  cfg_t                  cfg;
  logic                  en;
  logic                  div_vld;
  logic [COORD_BITS-1:0] quo_x, quo_y;
  logic [DEN_BITS-1:0]   rem_x, rem_y;
  logic                  slope_vld;
  tile_t                 slope_tile;
  tile_t                 out_tile;

  p2ht_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  p2ht_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_tvalid),
    .num_x   (in_tdata[COORD_BITS-1:0]),
    .num_y   (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .den_x   ({cfg.half_width, 1'b0}),
    .den_y   ({1'b0, cfg.row_height}),
    .out_vld (div_vld),
    .quo_x   (quo_x),
    .quo_y   (quo_y),
    .rem_x   (rem_x),
    .rem_y   (rem_y)
  );

  p2ht_slope u_slope (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .cfg     (cfg),
    .in_vld  (div_vld),
    .quo_x   (quo_x),
    .quo_y   (quo_y),
    .rem_x   (rem_x),
    .rem_y   (rem_y),
    .out_vld (slope_vld),
    .tile    (slope_tile)
  );

  p2ht_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (slope_vld),
    .in_tile    (slope_tile),
    .en         (en),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tile   (out_tile)
  );

  assign in_tready = en;
  assign out_tdata = OUT_W'(out_tile);

endmodule

// ===== hdl/p2ht_chk.sv =====
module p2ht_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic [p2ht_pkg::IN_W-1:0]   in_tdata,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [p2ht_pkg::OUT_W-1:0]  out_tdata,
  input logic                        cfg_psel,
  input logic                        cfg_penable,
  input logic                        cfg_pwrite,
  input logic [p2ht_pkg::ADDR_W-1:0] cfg_paddr,
  input logic [p2ht_pkg::DATA_W-1:0] cfg_pwdata,
  input logic [p2ht_pkg::DATA_W-1:0] cfg_prdata,
  input logic                        cfg_pready
);
  import p2ht_pkg::*;

  localparam int TOP = COORD_BITS + ROW_BITS;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result offered straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && $past(out_tvalid))
    else $error("input held off without a waiting result");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_W-1:TOP] == '0)
    else $error("nonzero padding in out_tdata");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[TOP-1] || (&out_tdata[TOP-1:COORD_BITS]))
    else $error("tile_row below -1");

endmodule

bind point_to_hex_tile_core p2ht_chk u_p2ht_chk (.*);

// ===== tb/tb.sv =====
module tb;
  import p2ht_pkg::*;

  localparam int  CLK_HALF   = 6;
  localparam int  IDLE_LIMIT = 4000;
  localparam int  N_PHASES   = 17;
  localparam int  PHASE_LEN  = 100;
  localparam int  TAIL_WAIT  = 40;
  localparam longint COORD_MAX = (longint'(1) << COORD_BITS) - 1;

  typedef struct {
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    bit                    known;
    tile_t                 tile;
  } probe_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [IN_W-1:0]     in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_W-1:0]    out_tdata;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0]   cfg_paddr = '0;
  logic [DATA_W-1:0]   cfg_pwdata = '0;
  logic [DATA_W-1:0]   cfg_prdata;
  logic                cfg_pready;

  point_to_hex_tile_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // point_x, point_y
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // tile_col, tile_row, zero pad
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  cfg_t   geo = '{HALF_WIDTH_RST, ROW_HEIGHT_RST, TILE_RISE_RST};
  tile_t  tiles_due[$];
  probe_t directed[$];
  bit     drv_known = 1'b0;
  tile_t  drv_tile = '0;
  bit     running = 1'b0;
  int     idle_cycles = 0;
  int     mismatches = 0;
  int     n_items = 0;
  int     n_tiles = 0;
  int     n_edge_tiles = 0;
  int     n_geometries = 0;
  int     burst_left = 0;
  int     stall_mode = 0;
  int     cyc = 0;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic tile_t locate_tile(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py);
    longint hw, rh, wide, x, y, ox, oy, r, lhs;
    tile_t  t;
    hw   = (geo.half_width == 0) ? 1 : longint'(geo.half_width);
    rh   = (geo.row_height == 0) ? 1 : longint'(geo.row_height);
    r    = longint'(geo.tile_rise);
    wide = 2 * hw;
    x    = longint'(px) / wide;
    y    = longint'(py) / rh;
    ox   = longint'(px) % wide;
    oy   = longint'(py) % rh;
    lhs  = oy * hw;
    if (y[0] == 1'b0) begin
      if (lhs < r * hw - r * ox) begin
        x = x - 1;
        y = y - 1;
      end else if (lhs < r * ox - r * hw) begin
        y = y - 1;
      end
    end else if (ox >= hw) begin
      if (lhs < 2 * r * hw - r * ox) y = y - 1;
    end else if (lhs < r * ox) begin
      y = y - 1;
    end else begin
      x = x - 1;
    end
    t.col = x[COORD_BITS-1:0];
    t.row = y[ROW_BITS-1:0];
    return t;
  endfunction

  task automatic note_mismatch(string what, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %h, got %h", what, want, got);
  endtask

  // item acceptance, result checking and watchdog
  always @(posedge clk) begin
    tile_t want;
    tile_t got;
    bit    moved;
    moved = 1'b0;
    if (rst_n && in_tvalid && in_tready) begin
      moved = 1'b1;
      n_items++;
      if (drv_known) tiles_due.push_back(drv_tile);
      else tiles_due.push_back(locate_tile(in_tdata[COORD_BITS-1:0],
                                           in_tdata[2*COORD_BITS-1:COORD_BITS]));
    end
    if (rst_n && out_tvalid && out_tready) begin
      moved = 1'b1;
      got = out_tdata[COORD_BITS+ROW_BITS-1:0];
      n_tiles++;
      if (got.col == '1 || got.row == '1) n_edge_tiles++;
      if (tiles_due.size() == 0) begin
        note_mismatch("unexpected tile", '0, DATA_W'(got.col));
      end else begin
        want = tiles_due.pop_front();
        if (got.col != want.col) note_mismatch("tile_col", DATA_W'(want.col), DATA_W'(got.col));
        if (got.row != want.row) note_mismatch("tile_row", DATA_W'(want.row), DATA_W'(got.row));
      end
    end
    if (running) begin
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // receiver stall pattern, one of four characters drawn at random
  always @(negedge clk) begin
    cyc++;
    if (cyc % 300 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: begin
        out_tready = 1'b1;
      end
      1: begin
        out_tready = ($urandom_range(0, 3) != 0);
      end
      2: begin
        out_tready = ((cyc % 7) < 4);
      end
      default: begin
        out_tready = ($urandom_range(0, 1) == 1);
      end
    endcase
  end

  task automatic send_point(logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py,
                            bit known, tile_t tile);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid = 1'b1;
    in_tdata  = {py, px};
    drv_known = known;
    drv_tile  = tile;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic drain;
    while (tiles_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [REG_BITS-1:0] val);
    case (idx)
      REG_HALF_WIDTH: geo.half_width = val;
      REG_ROW_HEIGHT: geo.row_height = val;
      default:        geo.tile_rise  = val;
    endcase
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = DATA_W'(val);
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_pwrite  = 1'b0;
    cfg_penable = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata != DATA_W'(val)) note_mismatch("register readback", DATA_W'(val), cfg_prdata);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  function automatic cfg_t geometry_for(int phase);
    cfg_t g;
    case (phase)
      0: g = '{16'd0, 16'd0, 16'd0};
      1: g = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
      2: g = '{16'd1, 16'd1, 16'd0};
      3: g = '{16'd1, 16'hFFFF, 16'hFFFF};
      4: g = '{16'hFFFF, 16'd1, 16'd0};
      5: g = '{16'd2, 16'd3, 16'hFFFF};
      6: g = '{HALF_WIDTH_RST, ROW_HEIGHT_RST, TILE_RISE_RST};
      default: begin
        g.half_width = ($urandom_range(0, 3) == 0) ? REG_BITS'($urandom_range(0, 65535))
                                                   : REG_BITS'($urandom_range(1, 2000));
        g.row_height = ($urandom_range(0, 3) == 0) ? REG_BITS'($urandom_range(0, 65535))
                                                   : REG_BITS'($urandom_range(1, 2000));
        g.tile_rise  = ($urandom_range(0, 3) == 0) ? REG_BITS'($urandom_range(0, 65535))
                                                   : REG_BITS'($urandom_range(0, 2000));
      end
    endcase
    return g;
  endfunction

  // mostly points placed on the slanted edges and near the origin
  task automatic aim_point(output logic [COORD_BITS-1:0] px, output logic [COORD_BITS-1:0] py);
    longint hw, rh, wide, cx, cy, ox;
    hw   = (geo.half_width == 0) ? 1 : longint'(geo.half_width);
    rh   = (geo.row_height == 0) ? 1 : longint'(geo.row_height);
    wide = 2 * hw;
    case ($urandom_range(0, 5))
      0, 1: begin
        cx = $urandom_range(0, COORD_MAX);
        cy = $urandom_range(0, COORD_MAX);
      end
      2: begin
        cx = $urandom_range(0, 4 * hw);
        cy = $urandom_range(0, 3 * rh);
      end
      default: begin
        case ($urandom_range(0, 3))
          0: ox = hw + int'($urandom_range(0, 4)) - 2;
          1: ox = $urandom_range(0, 3);
          2: ox = wide - 1 - int'($urandom_range(0, 3));
          default: ox = $urandom_range(0, wide - 1);
        endcase
        cx = longint'($urandom_range(0, COORD_MAX / wide)) * wide + ox;
        cy = longint'($urandom_range(0, COORD_MAX / rh)) * rh
             + $urandom_range(0, geo.tile_rise + 2);
      end
    endcase
    if (cx < 0) cx = 0;
    if (cx > COORD_MAX) cx = COORD_MAX;
    if (cy > COORD_MAX) cy = COORD_MAX;
    px = cx[COORD_BITS-1:0];
    py = cy[COORD_BITS-1:0];
  endtask

  initial begin
    logic [COORD_BITS-1:0] px, py;
    cfg_t g;

    // reset geometry: half width 443, row height 384, rise 128
    directed.push_back('{24'd0,       24'd0,       1'b1, '{25'h1FFFFFF, 24'hFFFFFF}});
    directed.push_back('{24'd443,     24'd0,       1'b1, '{25'd0, 24'd0}});
    directed.push_back('{24'd886,     24'd0,       1'b1, '{25'h1FFFFFF, 24'd0}});
    directed.push_back('{24'd0,       24'd384,     1'b1, '{25'd1, 24'hFFFFFF}});
    directed.push_back('{24'd443,     24'd384,     1'b1, '{25'd0, 24'd0}});
    directed.push_back('{24'd442,     24'd384,     1'b1, '{25'd0, 24'd0}});
    directed.push_back('{24'hFFFFFF,  24'hFFFFFF,  1'b1, '{25'd43690, 24'd18935}});
    directed.push_back('{24'hFFFFFF,  24'd0,       1'b0, '0});
    directed.push_back('{24'd0,       24'hFFFFFF,  1'b0, '0});
    directed.push_back('{24'd443,     24'd191,     1'b0, '0});
    directed.push_back('{24'd100,     24'd10,      1'b0, '0});
    directed.push_back('{24'd800,     24'd10,      1'b0, '0});
    directed.push_back('{24'd1329,    24'd404,     1'b0, '0});
    directed.push_back('{24'd885,     24'd383,     1'b0, '0});
    directed.push_back('{24'd3101,    24'd768,     1'b0, '0});
    directed.push_back('{24'hAAAAAA,  24'h555555,  1'b0, '0});
    directed.push_back('{24'h555555,  24'hAAAAAA,  1'b0, '0});
    directed.push_back('{24'd1,       24'd1,       1'b0, '0});
    directed.push_back('{24'd885,     24'd767,     1'b0, '0});
    directed.push_back('{24'd507,     24'd394,     1'b0, '0});

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n   = 1'b1;
    running = 1'b1;

    foreach (directed[i])
      send_point(directed[i].px, directed[i].py, directed[i].known, directed[i].tile);

    for (int phase = 0; phase < N_PHASES; phase++) begin
      in_tvalid = 1'b0;
      drain();
      g = geometry_for(phase);
      write_reg(REG_HALF_WIDTH, g.half_width);
      write_reg(REG_ROW_HEIGHT, g.row_height);
      write_reg(REG_TILE_RISE,  g.tile_rise);
      n_geometries++;
      for (int i = 0; i < PHASE_LEN; i++) begin
        if (phase == 8 && i == PHASE_LEN / 2) begin
          in_tvalid = 1'b0;
          drain();
        end
        aim_point(px, py);
        send_point(px, py, 1'b0, '0);
      end
    end
    in_tvalid = 1'b0;

    drain();
    repeat (TAIL_WAIT) @(posedge clk);
    if (tiles_due.size() != 0) note_mismatch("tiles still owed", '0, tiles_due.size());

    $display("%0d points over %0d geometries (zero, one and full-scale registers included)",
             n_items, n_geometries);
    $display("%0d tiles checked, %0d of them in column or row -1", n_tiles, n_edge_tiles);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
